// File: rtl/acfp_pkg.sv
// ----------------------------------------------------------------------------
// acfp_pkg
// Shared types and constants of the ASCII command frame parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

  // characters with a meaning of their own
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int NUM_FIELDS = 5;
  localparam int FIELD_W    = 3;
  localparam int COMMA_W    = 3;
  localparam int CNT_W      = 3;
  localparam int MAG_W      = 17;
  localparam int VAL_W      = 18;

  localparam logic [CNT_W-1:0]   TYPE_CHARS = 3'd2;
  localparam logic [CNT_W-1:0]   DATA_CHARS = 3'd5;
  localparam logic [COMMA_W-1:0] COMMA_MAX  = 3'd6;
  localparam logic [COMMA_W-1:0] COMMA_LAST_FIELD = 3'd5;

  localparam int QUEUE_DEPTH = 4;

  // time/1000 as (time * ceil(2^27/1000)) >> 27, exact below 493448
  localparam int               RECIP_SHIFT = 27;
  localparam logic [17:0]      RECIP_1000  = 18'd134218;
  localparam logic [7:0]       TIMER_BIAS  = 8'd30;
  localparam logic signed [VAL_W-1:0] CTRL_BASE = 18'sd100;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_CONTROL = 3'd1,
    KIND_FAULT   = 3'd2,
    KIND_ANGLES  = 3'd3,
    KIND_LINE    = 3'd4,
    KIND_DATE    = 3'd5,
    KIND_TIME    = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } cls_t;

  // classified character, front to back
  typedef struct packed {
    logic               feed;
    logic [FIELD_W-1:0] field;
    cls_t               cls;
    logic [3:0]         digit;
    logic               last;
  } entry_t;

  // field snapshot at the end of a buffer
  typedef struct packed {
    kind_t                   kind;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] c;
    logic signed [VAL_W-1:0] d;
    logic                    d_pos;
    logic [MAG_W-1:0]        d_mag;
  } snap_t;

endpackage

// File: rtl/acfp_intf.sv
// ----------------------------------------------------------------------------
// acfp channel interfaces
// Received byte channel and decoded frame channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface acfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface acfp_res_if;
  logic              valid;
  logic              ready;
  logic [2:0]        frame_kind;
  logic signed [17:0] value_a;
  logic signed [17:0] value_b;
  logic signed [17:0] value_c;
  logic signed [17:0] value_d;
  logic [7:0]        timer_load;
  logic              timer_start;

  modport source (output valid, output frame_kind, output value_a, output value_b,
                  output value_c, output value_d, output timer_load,
                  output timer_start, input ready);
  modport sink   (input valid, input frame_kind, input value_a, input value_b,
                  input value_c, input value_d, input timer_load,
                  input timer_start, output ready);
endinterface

// File: rtl/acfp_front.sv
// ----------------------------------------------------------------------------
// acfp_front
// Frame tracking: start mark, comma count, end of frame and buffer length.
// Classifies each byte and tags the field it belongs to.
// ----------------------------------------------------------------------------
module acfp_front #(
  parameter int BUFFER_LEN = 32
) (
  input  logic            clk,
  input  logic            rst,
  acfp_rx_if.sink         rx,
  input  logic            q_ready,
  output logic            push,
  output acfp_pkg::entry_t push_entry
);

  localparam int BCW = $clog2(BUFFER_LEN);

  logic                          started, started_next;
  logic                          finished, finished_next;
  logic [acfp_pkg::COMMA_W-1:0]  comma_count, comma_count_next;
  logic [BCW-1:0]                byte_count, byte_count_next;
  logic [7:0]                    c;
  logic                          last;
  logic                          is_digit;

  assign c        = rx.rx_byte;
  assign rx.ready = q_ready;
  assign push     = rx.valid && q_ready;
  assign is_digit = (c >= acfp_pkg::CH_ZERO) && (c <= acfp_pkg::CH_NINE);
  assign last     = rx.buffer_end || (byte_count >= BCW'(BUFFER_LEN - 1));

  always_comb begin
    push_entry.feed  = !finished && started && (c != acfp_pkg::CH_CR) &&
                       (c != acfp_pkg::CH_COMMA) && (comma_count != '0) &&
                       (comma_count <= acfp_pkg::COMMA_LAST_FIELD);
    push_entry.field = comma_count - 3'd1;
    push_entry.digit = c[3:0];
    push_entry.last  = last;
    if (c == acfp_pkg::CH_SPACE || (c >= acfp_pkg::CH_TAB && c <= acfp_pkg::CH_CR)) begin
      push_entry.cls = acfp_pkg::CLS_SPACE;
    end else if (c == acfp_pkg::CH_PLUS) begin
      push_entry.cls = acfp_pkg::CLS_PLUS;
    end else if (c == acfp_pkg::CH_MINUS) begin
      push_entry.cls = acfp_pkg::CLS_MINUS;
    end else if (is_digit) begin
      push_entry.cls = acfp_pkg::CLS_DIGIT;
    end else begin
      push_entry.cls = acfp_pkg::CLS_OTHER;
    end
  end

  always_comb begin
    started_next     = started;
    finished_next    = finished;
    comma_count_next = comma_count;
    byte_count_next  = byte_count + 1'b1;
    if (!finished) begin
      if (started) begin
        if (c == acfp_pkg::CH_CR) begin
          finished_next = 1'b1;
        end else if (c == acfp_pkg::CH_COMMA && comma_count < acfp_pkg::COMMA_MAX) begin
          comma_count_next = comma_count + 1'b1;
        end
      end
      if (c == acfp_pkg::CH_HASH) begin
        started_next = 1'b1;
      end
    end
    // end of buffer: everything back to idle
    if (last) begin
      started_next     = 1'b0;
      finished_next    = 1'b0;
      comma_count_next = '0;
      byte_count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      finished    <= 1'b0;
      comma_count <= '0;
      byte_count  <= '0;
    end else if (push) begin
      started     <= started_next;
      finished    <= finished_next;
      comma_count <= comma_count_next;
      byte_count  <= byte_count_next;
    end
  end

endmodule

// File: rtl/acfp_queue.sv
// ----------------------------------------------------------------------------
// acfp_queue
// Short FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module acfp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  acfp_pkg::entry_t push_entry,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output acfp_pkg::entry_t pop_entry
);

  localparam int PW = $clog2(acfp_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(acfp_pkg::QUEUE_DEPTH + 1);

  acfp_pkg::entry_t slot [acfp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign push_ready = (count != CW'(acfp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slot[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/acfp_back.sv
// ----------------------------------------------------------------------------
// acfp_back
// Per-field number decoders (spaces, sign, digits). On the last byte of a
// buffer the decoded fields are captured and the decoders cleared.
// ----------------------------------------------------------------------------
module acfp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  acfp_pkg::entry_t q_entry,
  output logic             pop,
  input  logic             adv,
  output logic             snap_valid,
  output acfp_pkg::snap_t  snap
);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  localparam int NF = acfp_pkg::NUM_FIELDS;
  localparam int MW = acfp_pkg::MAG_W;
  localparam int VW = acfp_pkg::VAL_W;

  logic [acfp_pkg::CNT_W-1:0] cnt [NF];
  phase_t                     phase [NF];
  logic                       neg [NF];
  logic [MW-1:0]              mag [NF];

  logic [acfp_pkg::CNT_W-1:0] cnt_upd [NF];
  phase_t                     phase_upd [NF];
  logic                       neg_upd [NF];
  logic [MW-1:0]              mag_upd [NF];

  logic                       take_last;
  acfp_pkg::snap_t            snap_new;
  logic [MW-1:0]              dig;

  // last entries need room in the result pipeline, the rest drain freely
  assign pop       = q_valid && (!q_entry.last || adv);
  assign take_last = pop && q_entry.last;
  assign dig       = MW'(q_entry.digit);

  always_comb begin
    for (int i = 0; i < NF; i++) begin
      cnt_upd[i]   = cnt[i];
      phase_upd[i] = phase[i];
      neg_upd[i]   = neg[i];
      mag_upd[i]   = mag[i];
      if (pop && q_entry.feed && q_entry.field == acfp_pkg::FIELD_W'(i) &&
          cnt[i] < ((i == 0) ? acfp_pkg::TYPE_CHARS : acfp_pkg::DATA_CHARS)) begin
        cnt_upd[i] = cnt[i] + 1'b1;
        case (phase[i])
          PH_SKIP: begin
            case (q_entry.cls)
              acfp_pkg::CLS_SPACE: phase_upd[i] = PH_SKIP;
              acfp_pkg::CLS_PLUS:  phase_upd[i] = PH_SIGN;
              acfp_pkg::CLS_MINUS: begin
                neg_upd[i]   = 1'b1;
                phase_upd[i] = PH_SIGN;
              end
              acfp_pkg::CLS_DIGIT: begin
                mag_upd[i]   = dig;
                phase_upd[i] = PH_DIGITS;
              end
              default: phase_upd[i] = PH_DONE;
            endcase
          end
          PH_SIGN: begin
            if (q_entry.cls == acfp_pkg::CLS_DIGIT) begin
              mag_upd[i]   = dig;
              phase_upd[i] = PH_DIGITS;
            end else begin
              phase_upd[i] = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (q_entry.cls == acfp_pkg::CLS_DIGIT) begin
              // x*10 as shifts, wraps at the accumulator width
              mag_upd[i] = (mag[i] << 3) + (mag[i] << 1) + dig;
            end else begin
              phase_upd[i] = PH_DONE;
            end
          end
          default: phase_upd[i] = PH_DONE;
        endcase
      end
    end
  end

  always_comb begin
    snap_new.a     = neg_upd[1] ? -VW'({1'b0, mag_upd[1]}) : VW'({1'b0, mag_upd[1]});
    snap_new.b     = neg_upd[2] ? -VW'({1'b0, mag_upd[2]}) : VW'({1'b0, mag_upd[2]});
    snap_new.c     = neg_upd[3] ? -VW'({1'b0, mag_upd[3]}) : VW'({1'b0, mag_upd[3]});
    snap_new.d     = neg_upd[4] ? -VW'({1'b0, mag_upd[4]}) : VW'({1'b0, mag_upd[4]});
    snap_new.d_pos = !neg_upd[4] && (mag_upd[4] != '0);
    snap_new.d_mag = mag_upd[4];
    snap_new.kind  = acfp_pkg::KIND_NONE;
    // a negative type never matches a known code
    if (!neg_upd[0]) begin
      case (mag_upd[0])
        MW'(1):  snap_new.kind = acfp_pkg::KIND_CONTROL;
        MW'(2):  snap_new.kind = acfp_pkg::KIND_FAULT;
        MW'(3):  snap_new.kind = acfp_pkg::KIND_ANGLES;
        MW'(4):  snap_new.kind = acfp_pkg::KIND_LINE;
        MW'(6):  snap_new.kind = acfp_pkg::KIND_DATE;
        MW'(7):  snap_new.kind = acfp_pkg::KIND_TIME;
        default: snap_new.kind = acfp_pkg::KIND_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NF; i++) begin
        cnt[i]   <= '0;
        phase[i] <= PH_SKIP;
        neg[i]   <= 1'b0;
        mag[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < NF; i++) begin
        if (take_last) begin
          cnt[i]   <= '0;
          phase[i] <= PH_SKIP;
          neg[i]   <= 1'b0;
          mag[i]   <= '0;
        end else begin
          cnt[i]   <= cnt_upd[i];
          phase[i] <= phase_upd[i];
          neg[i]   <= neg_upd[i];
          mag[i]   <= mag_upd[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (adv) begin
      snap_valid <= take_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take_last) begin
      snap <= snap_new;
    end
  end

endmodule

// File: rtl/acfp_result.sv
// ----------------------------------------------------------------------------
// acfp_result
// Frame kind post-processing: control inversion, unused fields cleared,
// fault timer load. Two stages ending in the output register.
// ----------------------------------------------------------------------------
module acfp_result (
  input  logic            clk,
  input  logic            rst,
  input  logic            snap_valid,
  input  acfp_pkg::snap_t snap,
  output logic            adv,
  acfp_res_if.source      res
);

  localparam int VW = acfp_pkg::VAL_W;
  localparam int PRW = acfp_pkg::MAG_W + 18;

  logic                   p2_valid;
  logic [2:0]             p2_kind;
  logic signed [VW-1:0]   p2_a, p2_b, p2_c, p2_d;
  logic                   p2_start;
  logic [7:0]             p2_quot;

  logic signed [VW-1:0]   a_fin, b_fin, c_fin, d_fin;
  logic [PRW-1:0]         prod;

  assign adv  = !res.valid || res.ready;
  assign prod = PRW'(snap.d_mag) * PRW'(acfp_pkg::RECIP_1000);

  always_comb begin
    a_fin = snap.a;
    b_fin = snap.b;
    c_fin = snap.c;
    d_fin = snap.d;
    case (snap.kind)
      acfp_pkg::KIND_CONTROL: begin
        b_fin = acfp_pkg::CTRL_BASE - snap.b;
        d_fin = acfp_pkg::CTRL_BASE - snap.d;
      end
      acfp_pkg::KIND_FAULT, acfp_pkg::KIND_ANGLES: begin
      end
      acfp_pkg::KIND_LINE: begin
        c_fin = '0;
        d_fin = '0;
      end
      acfp_pkg::KIND_DATE, acfp_pkg::KIND_TIME: begin
        d_fin = '0;
      end
      default: begin
        a_fin = '0;
        b_fin = '0;
        c_fin = '0;
        d_fin = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else if (adv) begin
      p2_valid  <= snap_valid;
      res.valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_kind  <= snap.kind;
      p2_a     <= a_fin;
      p2_b     <= b_fin;
      p2_c     <= c_fin;
      p2_d     <= d_fin;
      p2_start <= (snap.kind == acfp_pkg::KIND_FAULT) && snap.d_pos;
      p2_quot  <= prod[acfp_pkg::RECIP_SHIFT +: 8];

      res.frame_kind  <= p2_kind;
      res.value_a     <= p2_a;
      res.value_b     <= p2_b;
      res.value_c     <= p2_c;
      res.value_d     <= p2_d;
      res.timer_start <= p2_start;
      res.timer_load  <= p2_start ? (p2_quot + acfp_pkg::TIMER_BIAS) : 8'd0;
    end
  end

endmodule

// File: rtl/ascii_command_frame_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_command_frame_parser_core
// Decodes one '#'-started, comma-separated command frame per received buffer
// into a frame kind, four values and a fault timer load.
//
//   port  dir  width  contents
//   rx    in   8+1    rx_byte, buffer_end           (valid/ready)
//   res   out  3+4x18+8+1  frame_kind, value_a..d, timer_load, timer_start
//
// One byte per cycle sustained. After the buffer's last byte is taken, its result
// passes through queue, field capture, fixup/reciprocal multiply and output.
// A stalled result only holds last bytes; other bytes keep draining into the
// 4-entry queue, so rx.ready drops only once the queue fills.
// Reset (rst, synchronous) empties queue and pipeline and clears all fields.
// ----------------------------------------------------------------------------
module ascii_command_frame_parser_core #(
  parameter int BUFFER_LEN = 32
) (
  input  logic       clk,
  input  logic       rst,
  acfp_rx_if.sink    rx,
  acfp_res_if.source res
);

  logic             push, q_ready;
  acfp_pkg::entry_t push_entry;
  logic             pop, q_valid;
  acfp_pkg::entry_t q_entry;
  logic             adv, snap_valid;
  acfp_pkg::snap_t  snap;

  acfp_front #(
    .BUFFER_LEN (BUFFER_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  acfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  acfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop),
    .adv        (adv),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  acfp_result u_result (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .adv        (adv),
    .res        (res)
  );

endmodule

// File: dv/ascii_command_frame_parser_core_tb.sv
// ----------------------------------------------------------------------------
// ascii_command_frame_parser_core_tb
// Streams received buffers into the frame parser byte by byte and checks
// every decoded frame against an in-bench parser. Directed frames cover each
// frame kind and the odd text shapes; random well-formed frames, broken
// frames and raw noise follow under varying source and sink idling.
// ----------------------------------------------------------------------------
module ascii_command_frame_parser_core_tb;
  import acfp_pkg::*;

  localparam int BUF_LEN     = 32;
  localparam int RAND_BYTES  = 1420;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_TAIL  = 20;

  // frame type codes as they appear in the type field
  localparam int TYPE_CONTROL = 1;
  localparam int TYPE_FAULT   = 2;
  localparam int TYPE_ANGLES  = 3;
  localparam int TYPE_LINE    = 4;
  localparam int TYPE_DATE    = 6;
  localparam int TYPE_TIME    = 7;

  typedef enum int unsigned {
    PH_SPACE,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } field_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } rx_item_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] c;
    logic signed [VAL_W-1:0] d;
    logic [7:0]              load;
    logic                    start;
  } frame_t;

  logic clk;
  logic rst;

  acfp_rx_if  rx ();
  acfp_res_if res ();

  ascii_command_frame_parser_core #(.BUFFER_LEN(BUF_LEN)) dut (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .res(res)
  );

  // parser shadow state
  logic           in_frame;
  logic           frame_closed;
  int unsigned    comma_cnt;
  int unsigned    buf_pos;
  int unsigned    fld_len   [NUM_FIELDS];
  field_phase_t   fld_phase [NUM_FIELDS];
  logic           fld_neg   [NUM_FIELDS];
  logic [MAG_W-1:0] fld_mag [NUM_FIELDS];

  rx_item_t tx_bytes [$];
  frame_t   frames_due [$];

  int rx_wait;
  int res_wait;
  int rx_gap_max;
  int res_gap_max;
  logic res_block;
  logic hold_go;

  int errors;
  int bytes_queued;
  int bytes_sent;
  int frames_checked;
  int timer_hits;
  int kind_seen [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_parser();
    int i;
    in_frame     = 1'b0;
    frame_closed = 1'b0;
    comma_cnt    = 0;
    buf_pos      = 0;
    for (i = 0; i < NUM_FIELDS; i++) begin
      fld_len[i]   = 0;
      fld_phase[i] = PH_SPACE;
      fld_neg[i]   = 1'b0;
      fld_mag[i]   = '0;
    end
  endfunction

  function automatic void feed_field(int f, logic [7:0] ch);
    int               cap;
    logic             isdig;
    logic [MAG_W-1:0] dval;
    cap   = (f == 0) ? int'(TYPE_CHARS) : int'(DATA_CHARS);
    isdig = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dval  = ch[3:0];
    if (fld_len[f] >= cap) return;
    fld_len[f]++;
    case (fld_phase[f])
      PH_SPACE: begin
        if (ch == CH_PLUS) begin
          fld_phase[f] = PH_SIGN;
        end else if (ch == CH_MINUS) begin
          fld_neg[f]   = 1'b1;
          fld_phase[f] = PH_SIGN;
        end else if (isdig) begin
          fld_mag[f]   = dval;
          fld_phase[f] = PH_DIGITS;
        end else if (!(ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))) begin
          fld_phase[f] = PH_DONE;
        end
      end
      PH_SIGN: begin
        if (isdig) begin
          fld_mag[f]   = dval;
          fld_phase[f] = PH_DIGITS;
        end else begin
          fld_phase[f] = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (isdig) fld_mag[f] = fld_mag[f] * 10 + dval;  // wraps at MAG_W bits
        else fld_phase[f] = PH_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic int field_value(int f);
    return fld_neg[f] ? -int'(fld_mag[f]) : int'(fld_mag[f]);
  endfunction

  // advance the shadow parser by one byte; queue a frame on a buffer's last byte
  function automatic void parse_char(logic [7:0] ch, logic be);
    logic   last;
    int     typ, va, vb, vc, vd, ld;
    frame_t fr;
    last = be || (buf_pos >= BUF_LEN - 1);
    if (!frame_closed) begin
      if (in_frame) begin
        if (ch == CH_CR) begin
          frame_closed = 1'b1;
        end else if (ch == CH_COMMA) begin
          if (comma_cnt < COMMA_MAX) comma_cnt++;
        end else if (comma_cnt >= 1 && comma_cnt <= COMMA_LAST_FIELD) begin
          feed_field(comma_cnt - 1, ch);
        end
      end
      if (!frame_closed && ch == CH_HASH) in_frame = 1'b1;
    end
    buf_pos++;
    if (!last) return;

    typ = field_value(0);
    va  = field_value(1);
    vb  = field_value(2);
    vc  = field_value(3);
    vd  = field_value(4);
    ld  = 0;
    fr.start = 1'b0;
    case (typ)
      TYPE_CONTROL: begin
        fr.kind = KIND_CONTROL;
        vb = 100 - vb;
        vd = 100 - vd;
      end
      TYPE_FAULT: begin
        fr.kind = KIND_FAULT;
        if (vd > 0) begin
          ld = vd / 1000 + 30;
          fr.start = 1'b1;
        end
      end
      TYPE_ANGLES: fr.kind = KIND_ANGLES;
      TYPE_LINE: begin
        fr.kind = KIND_LINE;
        vc = 0;
        vd = 0;
      end
      TYPE_DATE: begin
        fr.kind = KIND_DATE;
        vd = 0;
      end
      TYPE_TIME: begin
        fr.kind = KIND_TIME;
        vd = 0;
      end
      default: begin
        fr.kind = KIND_NONE;
        va = 0;
        vb = 0;
        vc = 0;
        vd = 0;
      end
    endcase
    fr.a    = va[VAL_W-1:0];
    fr.b    = vb[VAL_W-1:0];
    fr.c    = vc[VAL_W-1:0];
    fr.d    = vd[VAL_W-1:0];
    fr.load = ld[7:0];
    frames_due.push_back(fr);
    clear_parser();
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : rx_driver
    rx_item_t it;
    if (rst) begin
      rx.valid <= 1'b0;
      rx_wait  <= 0;
    end else begin
      if (rx.valid && rx.ready) begin
        parse_char(rx.rx_byte, rx.buffer_end);
        bytes_sent++;
      end
      if (!rx.valid || rx.ready) begin
        if (rx_wait > 0) begin
          rx_wait  <= rx_wait - 1;
          rx.valid <= 1'b0;
        end else if (tx_bytes.size() > 0) begin
          it = tx_bytes.pop_front();
          rx.valid      <= 1'b1;
          rx.rx_byte    <= it.ch;
          rx.buffer_end <= it.last;
          rx_wait       <= $urandom_range(0, rx_gap_max);
        end else begin
          rx.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk) begin : res_monitor
    int     nw;
    frame_t want;
    if (rst) begin
      res.ready <= 1'b0;
      res_wait  <= 0;
    end else begin
      nw = res_wait;
      if (res.valid && res.ready) begin
        if (frames_due.size() == 0) begin
          errors++;
          $display({"%0t: unexpected frame: expected none, actual kind %0d",
                    " a %0d b %0d c %0d d %0d load %0d start %0d"},
                   $time, res.frame_kind, res.value_a, res.value_b, res.value_c,
                   res.value_d, res.timer_load, res.timer_start);
        end else begin
          want = frames_due.pop_front();
          check_field("frame_kind", int'(want.kind), int'(res.frame_kind));
          check_field("value_a", int'(want.a), int'(res.value_a));
          check_field("value_b", int'(want.b), int'(res.value_b));
          check_field("value_c", int'(want.c), int'(res.value_c));
          check_field("value_d", int'(want.d), int'(res.value_d));
          check_field("timer_load", int'(want.load), int'(res.timer_load));
          check_field("timer_start", int'(want.start), int'(res.timer_start));
          frames_checked++;
          kind_seen[want.kind]++;
          if (want.start) timer_hits++;
        end
        nw = $urandom_range(0, res_gap_max);
      end
      if (res_block) begin
        res.ready <= 1'b0;
        res_wait  <= nw;
      end else if (nw > 0) begin
        res.ready <= 1'b0;
        res_wait  <= nw - 1;
      end else begin
        res.ready <= 1'b1;
        res_wait  <= 0;
      end
    end
  end

  // long sink stall while the source keeps offering bytes
  initial begin : receiver_hold
    wait (hold_go);
    @(posedge clk);
    res_block <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    res_block <= 1'b0;
  end

  initial begin : watchdog
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // -------------------------------------------------------------- stimulus
  task automatic push_byte(input logic [7:0] ch, input logic last);
    rx_item_t it;
    it.ch   = ch;
    it.last = last;
    tx_bytes.push_back(it);
    bytes_queued++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  // "\015" is the carriage return that closes a frame
  task automatic send_frame(input int typ, input string body);
    send_text($sformatf("#,%0d,%s\015", typ, body));
  endtask

  function automatic string num_text(int maxlen);
    int len;
    len = $urandom_range(1, maxlen);
    return $sformatf("%0d", $urandom_range(0, 10 ** len - 1));
  endfunction

  function automatic string type_text();
    case ($urandom_range(0, 14))
      0, 1:    return $sformatf("%0d", TYPE_CONTROL);
      2, 3:    return $sformatf("%0d", TYPE_FAULT);
      4:       return $sformatf("%0d", TYPE_ANGLES);
      5:       return $sformatf("%0d", TYPE_LINE);
      6:       return $sformatf("%0d", TYPE_DATE);
      7:       return $sformatf("%0d", TYPE_TIME);
      8:       return "";
      9:       return $sformatf("%0d", $urandom_range(0, 99));
      10:      return $sformatf("-%0d", $urandom_range(0, 9));
      11:      return $sformatf(" %0d", $urandom_range(0, 9));
      12:      return $sformatf("+%0d", $urandom_range(0, 9));
      13:      return $sformatf("0%0d", $urandom_range(0, 9));
      default: return num_text(3);
    endcase
  endfunction

  function automatic string data_text();
    case ($urandom_range(0, 11))
      0:       return "";
      1:       return {" ", num_text(4)};
      2:       return {"-", num_text(4)};
      3:       return {"+", num_text(4)};
      4:       return num_text(7);
      5:       return {num_text(3), "x"};
      6:       return $sformatf("%c", $urandom_range(33, 126));
      7:       return {"\t-", num_text(3)};
      8:       return {"- ", num_text(2)};
      default: return num_text(5);
    endcase
  endfunction

  task automatic random_buffer();
    int    i, n, len;
    string s;
    if ($urandom_range(0, 4) == 0) begin
      // raw noise, sometimes without an end mark so it runs into the next buffer
      len = $urandom_range(1, 40);
      for (i = 0; i < len; i++)
        push_byte($urandom_range(0, 255), (i == len - 1) && ($urandom_range(0, 1) == 1));
    end else begin
      s = "";
      if ($urandom_range(0, 3) == 0) s = "AT";
      s = {s, "#"};
      if ($urandom_range(0, 5) == 0) s = {s, "x9"};
      s = {s, ",", type_text()};
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : 4;
      for (i = 0; i < n; i++) s = {s, ",", data_text()};
      if ($urandom_range(0, 9) != 0) s = {s, "\015"};
      if ($urandom_range(0, 7) == 0) s = {s, "#,1"};
      send_text(s);
    end
  endtask

  task automatic drain();
    while (tx_bytes.size() > 0 || rx.valid || frames_due.size() > 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int    p, i, target;
    string s;
    rst           = 1'b1;
    rx.valid      = 1'b0;
    rx.rx_byte    = '0;
    rx.buffer_end = 1'b0;
    res.ready     = 1'b0;
    rx_gap_max    = 0;
    res_gap_max   = 0;
    res_block     = 1'b0;
    hold_go       = 1'b0;
    errors        = 0;
    bytes_queued  = 0;
    bytes_sent    = 0;
    frames_checked = 0;
    timer_hits    = 0;
    for (i = 0; i < 8; i++) kind_seen[i] = 0;
    clear_parser();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed frames
    send_frame(TYPE_CONTROL, "0,0,0,0");
    send_frame(TYPE_CONTROL, "99999,-99999,100,+7");
    send_frame(TYPE_FAULT, "1,2,3,99999");
    send_frame(TYPE_FAULT, "5,6,7,999");
    send_frame(TYPE_FAULT, "5,6,7,0");
    send_frame(TYPE_FAULT, "5,6,7,-1000");
    send_frame(TYPE_ANGLES, "-1,+2, 3,\t4");
    send_frame(TYPE_LINE, "12,34,56,78");
    send_frame(TYPE_DATE, "28,2,99,9");
    send_frame(TYPE_TIME, "23,59,58,1");
    send_text("#,5,1,2,3,4\015");
    send_text("#,-1,1,2,3,4\015");
    send_text("no frame here\015");
    send_frame(TYPE_ANGLES, "1234567,99999999,-123456,+98765");
    send_frame(TYPE_ANGLES, "1,2,3,4,5,6,7");
    send_text($sformatf("#ab,%0d,1,2,3,4\015", TYPE_LINE));
    send_text($sformatf("#,%0d,1,2,3,4\015#,%0d,9", TYPE_ANGLES, TYPE_CONTROL));
    send_frame(TYPE_ANGLES, "1#2,#3,4,5");
    send_text($sformatf("#,%0d, \t\n7,%c%c8,1,2\015", TYPE_ANGLES, 8'd11, 8'd12));
    send_frame(TYPE_ANGLES, ",,,");
    send_frame(TYPE_ANGLES, "-,+,--1,+-2");
    send_text("#, 1,5,5,5,5\015#,+2,1,1,1,1500\015");
    send_text("#,07,1,2,3,4\015");
    // buffer ended by its length alone
    s = $sformatf("#,%0d,1,2,3,4", TYPE_ANGLES);
    while (s.len() < BUF_LEN) s = {s, " "};
    for (i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_HASH, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(CH_HASH, 1'b1);
    push_byte(8'h7F, 1'b1);
    send_text($sformatf("#,%0d,12,3", TYPE_CONTROL));
    drain();

    // random phases: no idling, source idling, sink idling, both
    for (p = 0; p < 4; p++) begin
      rx_gap_max  = (p % 2 == 1) ? 9 : 0;
      res_gap_max = (p >= 2) ? 9 : 0;
      if (p == 0) hold_go = 1'b1;
      target = bytes_queued + RAND_BYTES / 4;
      while (bytes_queued < target) random_buffer();
      drain();
    end
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Covered %0d bytes, %0d frames checked, %0d fault timer loads",
             bytes_sent, frames_checked, timer_hits);
    $display("Kinds none/control/fault/angles/line/date/time: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4], kind_seen[5], kind_seen[6]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
